### rtl/core/dlhw_pkg.sv
// Shared constants, codes and types of the delay-line hit wire decoder.
package dlhw_pkg;

	// Sizes
	localparam int RIGHT_DEPTH = 16;
	localparam int LEFT_DEPTH  = 16;
	localparam int WINDOWS     = 8;
	localparam int WIRE_STEP   = 8;

	localparam int RIGHT_AW   = $clog2(RIGHT_DEPTH);
	localparam int CNT_W      = $clog2(RIGHT_DEPTH + 1);
	localparam int LCNT_W     = $clog2(LEFT_DEPTH + 1);
	localparam int WIN_W      = $clog2(WINDOWS);
	localparam int IDX_W      = 4;
	localparam int TIME_W     = 16;
	localparam int DIFF_W     = TIME_W + 1;
	localparam int WIRE_W     = 11;
	localparam int FWIRE_W    = 10;
	localparam int WCNT_W     = 4;
	localparam int KIND_W     = 2;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Input opcodes
	localparam logic [OP_W-1:0] OP_STORE = 2'd0;
	localparam logic [OP_W-1:0] OP_MATCH = 2'd1;
	localparam logic [OP_W-1:0] OP_EVENT = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WIRE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLIP_SIGN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWS_A       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWS_B       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGHS_A      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGHS_B      = 3'd6;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PAIR   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

	// Window configuration as seen by the match logic
	typedef struct packed {
		logic [FWIRE_W-1:0]              first_wire;
		logic [WCNT_W-1:0]               window_count;
		logic [WINDOWS-1:0][TIME_W-1:0]  lows;
		logic [WINDOWS-1:0][TIME_W-1:0]  highs;
	} dlhw_win_cfg_t;

	// Decoded pairing without the per-left-hit fields
	typedef struct packed {
		logic [IDX_W-1:0]  right_index;
		logic [WIRE_W-1:0] wire_number;
		logic [WIRE_W-1:0] other_wire;
		logic [KIND_W-1:0] match_kind;
	} dlhw_match_t;

endpackage

### rtl/core/dlhw_if.sv
// Handshake channels for hit items and result items.
interface dlhw_in_if;
	logic                              valid;
	logic                              ready;
	logic [dlhw_pkg::OP_W-1:0]         opcode;
	logic signed [dlhw_pkg::TIME_W-1:0] hit_time;

	modport source (output valid, opcode, hit_time, input ready);
	modport sink   (input valid, opcode, hit_time, output ready);
endinterface

interface dlhw_out_if;
	logic                              valid;
	logic                              ready;
	logic [dlhw_pkg::IDX_W-1:0]        left_index;
	logic [dlhw_pkg::IDX_W-1:0]        right_index;
	logic [dlhw_pkg::WIRE_W-1:0]       wire_number;
	logic [dlhw_pkg::WIRE_W-1:0]       other_wire;
	logic [dlhw_pkg::KIND_W-1:0]       match_kind;
	logic                              last;

	modport source (output valid, left_index, right_index, wire_number, other_wire,
		match_kind, last, input ready);
	modport sink   (input valid, left_index, right_index, wire_number, other_wire,
		match_kind, last, output ready);
endinterface

### rtl/core/dlhw_window_match.sv
// Window search: classifies one time difference against the window table.
module dlhw_window_match (
	input  logic signed [dlhw_pkg::DIFF_W-1:0] diff,
	input  logic [dlhw_pkg::IDX_W-1:0]         right_index,
	input  dlhw_pkg::dlhw_win_cfg_t            cfg,
	output logic                               hit,
	output dlhw_pkg::dlhw_match_t              res
);

	logic signed [dlhw_pkg::DIFF_W-1:0] lo_x [dlhw_pkg::WINDOWS];
	logic signed [dlhw_pkg::DIFF_W-1:0] hi_x [dlhw_pkg::WINDOWS];
	logic [dlhw_pkg::WINDOWS-1:0]       in_win;
	logic [dlhw_pkg::WINDOWS-1:0]       gap_win;
	logic [dlhw_pkg::WCNT_W-1:0]        nw;
	logic [dlhw_pkg::WIN_W-1:0]         top;
	logic [dlhw_pkg::WIN_W-1:0]         sel;
	logic                               found;
	logic                               sel_inside;
	logic [dlhw_pkg::WIRE_W-1:0]        wire_num;

	// Windows in use: zero counts as one, clamp at the table size
	always_comb begin
		if (cfg.window_count == '0) begin
			nw = dlhw_pkg::WCNT_W'(1);
		end else if (cfg.window_count > dlhw_pkg::WCNT_W'(dlhw_pkg::WINDOWS)) begin
			nw = dlhw_pkg::WCNT_W'(dlhw_pkg::WINDOWS);
		end else begin
			nw = cfg.window_count;
		end
		top = dlhw_pkg::WIN_W'(nw - dlhw_pkg::WCNT_W'(1));
	end

	// Per-window inside and gap tests, all in parallel
	always_comb begin
		for (int i = 0; i < dlhw_pkg::WINDOWS; i++) begin
			lo_x[i] = dlhw_pkg::DIFF_W'($signed(cfg.lows[i]));
			hi_x[i] = dlhw_pkg::DIFF_W'($signed(cfg.highs[i]));
		end
		for (int i = 0; i < dlhw_pkg::WINDOWS; i++) begin
			in_win[i] = (diff >= lo_x[i]) && (diff < hi_x[i]);
		end
		gap_win[0] = 1'b0;
		for (int i = 1; i < dlhw_pkg::WINDOWS; i++) begin
			gap_win[i] = (diff < lo_x[i]) && (diff >= hi_x[i-1]);
		end
	end

	// Highest window in use with a passing test wins
	always_comb begin
		found      = 1'b0;
		sel        = '0;
		sel_inside = 1'b0;
		for (int i = 0; i < dlhw_pkg::WINDOWS; i++) begin
			if ((i < int'(nw)) && (in_win[i] || gap_win[i])) begin
				found      = 1'b1;
				sel        = dlhw_pkg::WIN_W'(i);
				sel_inside = in_win[i];
			end
		end
	end

	// Range gate and result fields
	always_comb begin
		hit  = !((diff < lo_x[0]) || (diff > hi_x[top]));
		wire_num = dlhw_pkg::WIRE_W'(cfg.first_wire)
			+ dlhw_pkg::WIRE_W'(int'(sel) * dlhw_pkg::WIRE_STEP);
		res.right_index = right_index;
		if (!found) begin
			res.match_kind  = dlhw_pkg::KIND_NONE;
			res.wire_number = '0;
			res.other_wire  = '0;
		end else if (sel_inside) begin
			res.match_kind  = dlhw_pkg::KIND_SINGLE;
			res.wire_number = wire_num;
			res.other_wire  = '0;
		end else begin
			res.match_kind  = dlhw_pkg::KIND_PAIR;
			res.wire_number = wire_num;
			res.other_wire  = wire_num - dlhw_pkg::WIRE_W'(dlhw_pkg::WIRE_STEP);
		end
	end

endmodule

### rtl/core/delay_line_hit_wire_decoder.sv
// Top level of the delay-line hit wire decoder.
// Usage:
//   hits carries items of {opcode, hit_time}: store a right-end hit, match a
//   left-end hit, or start a new event. results carries one item per pairing
//   whose time difference falls in the window table range; last marks the
//   final result of a left hit. The config port writes one register per
//   cycle with cfg_we; use it only while the block is idle (not enforced).
// Flow:
//   Store and new-event items are taken while idle and keep the block idle. A
//   left hit walks the stored right hits through the right-time RAM, one read
//   per cycle unless stalled, then two stages (difference, window search) and
//   a one-result hold that sets last. A left hit with no stored right hits
//   ends without a walk. A result is held until the next pairing that decodes
//   reaches the hold, the final one until the walk drains, then it enters the
//   output register. The single RAM read port sets the walk rate.
// Stalls: the output register holds a result while the receiver stalls; the
//   walk stops only when a new result, a held result and a full output
//   register meet. hits.ready is low during a walk.
// Reset: counters clear, registers take their reset values (window_count 8);
//   the RAM is not cleared, only entries below the stored count are read.
module delay_line_hit_wire_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dlhw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dlhw_pkg::CFG_DATA_W-1:0]     cfg_data,
	dlhw_in_if.sink                             hits,
	dlhw_out_if.source                          results
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [dlhw_pkg::FWIRE_W-1:0]    first_wire_q;
	logic                            flip_sign_q;
	logic [dlhw_pkg::WCNT_W-1:0]     window_count_q;
	logic [dlhw_pkg::CFG_DATA_W-1:0] lows_a_q, lows_b_q, highs_a_q, highs_b_q;
	dlhw_pkg::dlhw_win_cfg_t         win_cfg;

	// Event state
	logic [dlhw_pkg::CNT_W-1:0]      right_count_q;
	logic [dlhw_pkg::LCNT_W-1:0]     left_count_q;
	logic [dlhw_pkg::IDX_W-1:0]      li_q;
	logic signed [dlhw_pkg::TIME_W-1:0] t_q;
	logic [dlhw_pkg::CNT_W-1:0]      j_q;

	// Right-time RAM
	logic [dlhw_pkg::TIME_W-1:0]     right_mem [dlhw_pkg::RIGHT_DEPTH];
	logic [dlhw_pkg::TIME_W-1:0]     rdata_s1;
	logic                            wr_en, rd_en;

	// Pipeline
	logic                            v_s1, v_s2;
	logic [dlhw_pkg::IDX_W-1:0]      j_s1, j_s2;
	logic signed [dlhw_pkg::DIFF_W-1:0] diff, d_s2;
	logic signed [dlhw_pkg::DIFF_W-1:0] r_x, t_x;
	logic                            hit;
	dlhw_pkg::dlhw_match_t           cand;

	// Held result and output register
	logic                            pend_v_q;
	dlhw_pkg::dlhw_match_t           pend_q;
	logic                            out_v_q;
	dlhw_pkg::dlhw_match_t           out_q;
	logic [dlhw_pkg::IDX_W-1:0]      out_li_q;
	logic                            out_last_q;

	logic accept, issue_v, out_free, cand_v, adv, drained, push_mid, push_end, push;
	logic start_walk;

	// Handshake and control
	assign hits.ready = (state_q == ST_IDLE);
	assign accept     = hits.valid && hits.ready;
	assign wr_en      = accept && (hits.opcode == dlhw_pkg::OP_STORE)
		&& (right_count_q < dlhw_pkg::CNT_W'(dlhw_pkg::RIGHT_DEPTH));
	assign start_walk = accept && (hits.opcode == dlhw_pkg::OP_MATCH)
		&& (left_count_q < dlhw_pkg::LCNT_W'(dlhw_pkg::LEFT_DEPTH));

	assign issue_v  = (state_q == ST_RUN) && (j_q != right_count_q);
	assign out_free = !out_v_q || results.ready;
	assign cand_v   = v_s2 && hit;
	assign adv      = !(cand_v && pend_v_q && !out_free);
	assign rd_en    = adv && issue_v;
	assign drained  = (state_q == ST_RUN) && !issue_v && !v_s1 && !v_s2;
	assign push_mid = adv && cand_v && pend_v_q;
	assign push_end = drained && pend_v_q && out_free;
	assign push     = push_mid || push_end;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_wire_q   <= '0;
			flip_sign_q    <= 1'b0;
			window_count_q <= dlhw_pkg::WCNT_W'(dlhw_pkg::WINDOWS);
			lows_a_q       <= '0;
			lows_b_q       <= '0;
			highs_a_q      <= '0;
			highs_b_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dlhw_pkg::CFG_FIRST_WIRE:   first_wire_q   <= cfg_data[dlhw_pkg::FWIRE_W-1:0];
				dlhw_pkg::CFG_FLIP_SIGN:    flip_sign_q    <= cfg_data[0];
				dlhw_pkg::CFG_WINDOW_COUNT: window_count_q <= cfg_data[dlhw_pkg::WCNT_W-1:0];
				dlhw_pkg::CFG_LOWS_A:       lows_a_q       <= cfg_data;
				dlhw_pkg::CFG_LOWS_B:       lows_b_q       <= cfg_data;
				dlhw_pkg::CFG_HIGHS_A:      highs_a_q      <= cfg_data;
				dlhw_pkg::CFG_HIGHS_B:      highs_b_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		win_cfg.first_wire   = first_wire_q;
		win_cfg.window_count = window_count_q;
		win_cfg.lows         = {lows_b_q, lows_a_q};
		win_cfg.highs        = {highs_b_q, highs_a_q};
	end

	// Sequencer: event counters and the walk over stored right hits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			right_count_q <= '0;
			left_count_q  <= '0;
			j_q           <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (hits.opcode == dlhw_pkg::OP_EVENT)) begin
						right_count_q <= '0;
						left_count_q  <= '0;
					end
					if (wr_en) begin
						right_count_q <= right_count_q + dlhw_pkg::CNT_W'(1);
					end
					if (start_walk) begin
						left_count_q <= left_count_q + dlhw_pkg::LCNT_W'(1);
						j_q          <= '0;
						if (right_count_q != '0) begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (rd_en) begin
						j_q <= j_q + dlhw_pkg::CNT_W'(1);
					end
					if (drained && (!pend_v_q || out_free)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Left hit time and order number for the walk
	always_ff @(posedge clk) begin
		if (start_walk) begin
			t_q  <= hits.hit_time;
			li_q <= dlhw_pkg::IDX_W'(left_count_q);
		end
	end

	// Right-time RAM: written while idle, read during a walk
	always_ff @(posedge clk) begin
		if (wr_en) begin
			right_mem[right_count_q[dlhw_pkg::RIGHT_AW-1:0]] <= hits.hit_time;
		end
		if (rd_en) begin
			rdata_s1 <= right_mem[j_q[dlhw_pkg::RIGHT_AW-1:0]];
		end
	end

	// Stage 1: time difference
	always_comb begin
		r_x  = dlhw_pkg::DIFF_W'($signed(rdata_s1));
		t_x  = dlhw_pkg::DIFF_W'(t_q);
		diff = flip_sign_q ? (t_x - r_x) : (r_x - t_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			j_s1 <= dlhw_pkg::IDX_W'(j_q);
			j_s2 <= j_s1;
			d_s2 <= diff;
		end
	end

	// Stage 2: window search
	dlhw_window_match u_match (
		.diff        (d_s2),
		.right_index (j_s2),
		.cfg         (win_cfg),
		.hit         (hit),
		.res         (cand)
	);

	// Hold one result back so the final one of a left hit can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (adv && cand_v) begin
			pend_v_q <= 1'b1;
		end else if (push_end) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cand_v) begin
			pend_q <= cand;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push) begin
			out_v_q <= 1'b1;
		end else if (results.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q      <= pend_q;
			out_li_q   <= li_q;
			out_last_q <= push_end;
		end
	end

	assign results.valid       = out_v_q;
	assign results.left_index  = out_li_q;
	assign results.right_index = out_q.right_index;
	assign results.wire_number = out_q.wire_number;
	assign results.other_wire  = out_q.other_wire;
	assign results.match_kind  = out_q.match_kind;
	assign results.last        = out_last_q;

	// Checks
	a_pend_only_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_IDLE && pend_v_q))
		else $error("held result left behind after walk");

	a_read_only_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && state_q == ST_IDLE))
		else $error("RAM read issued while idle");

	a_index_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (dlhw_pkg::CNT_W'(j_s2) < right_count_q))
		else $error("pairing with an unwritten right hit");

	a_drain_exits: assert property (@(posedge clk) disable iff (!arst_n)
		(drained && !pend_v_q) |=> (state_q == ST_IDLE))
		else $error("walk did not finish after drain");

	a_stall_holds_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_v_q && !adv) |=> (pend_v_q && $stable(pend_q)))
		else $error("held result lost during stall");

endmodule
